// File: src/gtpf_pkg.sv
// ----------------------------------------------------------------------------
// gtpf_pkg
// Types and constants shared by the gradient threshold pixel filter modules.
// ----------------------------------------------------------------------------
package gtpf_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd5;

  // Output rules
  localparam logic [2:0] MODE_RAW       = 3'd1;
  localparam logic [2:0] MODE_GRAD_ORIG = 3'd2;
  localparam logic [2:0] MODE_GRAD_LOW  = 3'd3;
  localparam logic [2:0] MODE_HIGH_ORIG = 3'd4;
  localparam logic [2:0] MODE_HIGH_LOW  = 3'd5;

  // Request types
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Register reset values
  localparam logic [2:0]  RST_MODE        = MODE_RAW;
  localparam logic [10:0] RST_THRESHOLD   = 11'd100;
  localparam logic [7:0]  RST_LOW_LEVEL   = 8'd255;
  localparam logic [7:0]  RST_HIGH_LEVEL  = 8'd128;
  localparam logic        RST_COLOUR_MODE = 1'b0;
  localparam logic [10:0] RST_ROW_WIDTH   = 11'd1024;

  // Gradient range: up to 6 * 255 = 1530
  localparam int GRAD_W = 11;
  localparam logic [GRAD_W-1:0] GRAD_SAT = 11'd255;

  typedef struct packed {
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pix_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic       row_end;
  } res_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [GRAD_W-1:0] threshold;
    logic [7:0]        low_level;
    logic [7:0]        high_level;
    logic              colour_mode;
  } grad_cfg_t;

  // Neighborhood of the buffered pixel at the current column
  typedef struct packed {
    pix_t up;
    pix_t right;
    logic last;
    logic held;
  } nbr_t;

endpackage

// File: src/gtpf_line_buf.sv
// ----------------------------------------------------------------------------
// gtpf_line_buf
// Line buffer for the previous row with prefetch of the current column and
// its right neighbor, column counter and row-held flag.
// ----------------------------------------------------------------------------
module gtpf_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 is_flush,
  input  gtpf_pkg::pix_t       cur,
  input  logic [10:0]          row_width,
  output gtpf_pkg::nbr_t       nbr
);
  import gtpf_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (CW + 1 > 11) ? CW + 1 : 11;

  pix_t mem [MAX_WIDTH];

  logic [CW-1:0] col, col_next;
  logic          held, held_next;
  pix_t          up_q, up_q_next, right_q, right_q_next;
  logic          up_mem, up_mem_next, right_mem, right_mem_next;
  pix_t          rd0, rd1;
  logic          rd0_en, rd1_en;
  logic [CW-1:0] ra1;
  logic [CW-1:0] ra_p2;
  logic [LW-1:0] col_p2, w_eff;
  pix_t          up, right, wval;
  logic          last, act;

  // Current column pixel and right neighbor: fresh read data or held copy
  assign up    = up_mem    ? rd0 : up_q;
  assign right = right_mem ? rd1 : right_q;

  always_comb begin
    if (row_width == 11'd0) begin
      w_eff = LW'(1);
    end else if (LW'(row_width) > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = LW'(row_width);
    end
  end

  assign last   = (LW'(col) + LW'(1)) >= w_eff;
  assign col_p2 = LW'(col) + LW'(2);
  assign ra_p2  = (col_p2 >= LW'(MAX_WIDTH)) ? '0 : col_p2[CW-1:0];

  // A flush with no row held changes nothing
  assign act  = step && !(is_flush && !held);
  assign wval = is_flush ? up : cur;

  always_comb begin
    col_next       = col;
    held_next      = held;
    up_q_next      = up;
    right_q_next   = right;
    up_mem_next    = 1'b0;
    right_mem_next = 1'b0;
    rd0_en         = 1'b0;
    rd1_en         = 1'b0;
    ra1            = ra_p2;
    if (act) begin
      if (!last) begin
        // advance: right neighbor becomes current, fetch the one after it
        col_next       = col + CW'(1);
        up_q_next      = right;
        right_mem_next = 1'b1;
        rd1_en         = 1'b1;
      end else begin
        // wrap to column 0 of the row just stored
        col_next  = '0;
        held_next = !is_flush;
        if (col == '0) begin
          up_q_next      = wval;
          right_mem_next = 1'b1;
          rd1_en         = 1'b1;
          ra1            = CW'(1);
        end else if (col == CW'(1)) begin
          up_mem_next  = 1'b1;
          rd0_en       = 1'b1;
          right_q_next = wval;
        end else begin
          up_mem_next    = 1'b1;
          rd0_en         = 1'b1;
          right_mem_next = 1'b1;
          rd1_en         = 1'b1;
          ra1            = CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act && !is_flush) begin
      mem[col] <= cur;
    end
    if (rd0_en) begin
      rd0 <= mem[0];
    end
    if (rd1_en) begin
      rd1 <= mem[ra1];
    end
  end

  always_ff @(posedge clk) begin
    up_q    <= up_q_next;
    right_q <= right_q_next;
    if (rst) begin
      col       <= '0;
      held      <= 1'b0;
      up_mem    <= 1'b0;
      right_mem <= 1'b0;
    end else begin
      col       <= col_next;
      held      <= held_next;
      up_mem    <= up_mem_next;
      right_mem <= right_mem_next;
    end
  end

  // The last column of a row is its own right neighbor
  assign nbr.up    = up;
  assign nbr.right = last ? up : right;
  assign nbr.last  = last;
  assign nbr.held  = held;

endmodule

// File: src/gtpf_grad.sv
// ----------------------------------------------------------------------------
// gtpf_grad
// Forward-difference gradient, threshold compare and output rule selection.
// ----------------------------------------------------------------------------
module gtpf_grad (
  input  gtpf_pkg::grad_cfg_t cfg,
  input  gtpf_pkg::nbr_t      nbr,
  input  logic                is_flush,
  input  gtpf_pkg::pix_t      cur,
  output gtpf_pkg::res_t      res
);
  import gtpf_pkg::*;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  pix_t              below;
  logic [8:0]        d0, d1, d2;
  logic [GRAD_W-1:0] grad;
  logic [7:0]        grad_sat, lvl;
  logic [2:0]        m;
  logic              is_edge, use_grad, use_lvl;

  // On flush the pixel below is the pixel itself
  assign below = is_flush ? nbr.up : cur;

  assign d0 = {1'b0, absdiff(nbr.up.c0, below.c0)} + {1'b0, absdiff(nbr.up.c0, nbr.right.c0)};
  assign d1 = {1'b0, absdiff(nbr.up.c1, below.c1)} + {1'b0, absdiff(nbr.up.c1, nbr.right.c1)};
  assign d2 = {1'b0, absdiff(nbr.up.c2, below.c2)} + {1'b0, absdiff(nbr.up.c2, nbr.right.c2)};

  assign grad = cfg.colour_mode ? (GRAD_W'(d0) + GRAD_W'(d1) + GRAD_W'(d2)) : GRAD_W'(d0);
  assign grad_sat = (grad > GRAD_SAT) ? 8'hFF : grad[7:0];
  assign is_edge  = grad >= cfg.threshold;

  // Unknown rule codes fall back to raw gradient
  assign m = (cfg.mode < MODE_RAW || cfg.mode > MODE_HIGH_LOW) ? MODE_RAW : cfg.mode;

  assign use_grad = (m == MODE_RAW) ||
                    (is_edge && (m == MODE_GRAD_ORIG || m == MODE_GRAD_LOW));
  assign use_lvl  = (is_edge && (m == MODE_HIGH_ORIG || m == MODE_HIGH_LOW)) ||
                    (!is_edge && (m == MODE_GRAD_LOW || m == MODE_HIGH_LOW));
  assign lvl      = is_edge ? cfg.high_level : cfg.low_level;

  always_comb begin
    res         = '0;
    res.row_end = nbr.last;
    if (use_grad) begin
      res.c0 = grad_sat;
      if (cfg.colour_mode) begin
        res.c1 = grad_sat;
        res.c2 = grad_sat;
      end
    end else if (use_lvl) begin
      if (cfg.colour_mode) begin
        res.c2 = lvl;
      end else begin
        res.c0 = lvl;
      end
    end else begin
      res.c0 = nbr.up.c0;
      if (cfg.colour_mode) begin
        res.c1 = nbr.up.c1;
        res.c2 = nbr.up.c2;
      end
    end
  end

endmodule

// File: src/gtpf_out_buf.sv
// ----------------------------------------------------------------------------
// gtpf_out_buf
// Result register with a skid entry so input and output stall independently.
// ----------------------------------------------------------------------------
module gtpf_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gtpf_pkg::res_t din,
  input  logic           out_ready,
  output logic           can_take,
  output logic           out_valid,
  output gtpf_pkg::res_t dout
);
  import gtpf_pkg::*;

  res_t skid;
  logic skid_valid;
  logic pop;

  assign pop      = out_valid && out_ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          dout       <= skid;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
          dout      <= din;
        end
      end else if (!out_valid) begin
        out_valid <= push;
        dout      <= din;
      end else if (push) begin
        // hold the new word until the output drains
        skid       <= din;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

// File: src/gradient_threshold_pixel_filter_core.sv
// ----------------------------------------------------------------------------
// gradient_threshold_pixel_filter_core
// Forward-difference gradient edge filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per pixel in raster order,
//   req_type selects a new pixel or a flush tick. The first row only fills
//   the line buffer; each pixel of later rows yields the result for the
//   pixel one row above. Flush ticks drain the last buffered row.
//   Output channel (out_valid/out_ready): one result word, row_end marks the
//   last pixel of a row.
//   Each result is registered, in the skid entry if the output stalls.
//   Throughput: one word per cycle while in_ready is high, set by the single
//   line buffer write plus the prefetch reads of current and right columns.
//   Stall: a skid entry behind the result register lets one more word in
//   while the receiver holds out_ready low; after that in_ready drops.
//   Reset: clears the column count and the row-held flag; registers take
//   their default values. The line buffer is not cleared and needs no
//   clearing pass: a row is always written before it is read.
//   Configuration (cfg_we/cfg_index/cfg_data): write only while idle.
// ----------------------------------------------------------------------------
module gradient_threshold_pixel_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  pix_c0,
  input  logic [7:0]  pix_c1,
  input  logic [7:0]  pix_c2,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_c0,
  output logic [7:0]  out_c1,
  output logic [7:0]  out_c2,
  output logic        row_end
);
  import gtpf_pkg::*;

  // Configuration registers
  logic [2:0]        mode;
  logic [GRAD_W-1:0] threshold;
  logic [7:0]        low_level;
  logic [7:0]        high_level;
  logic              colour_mode;
  logic [10:0]       row_width;

  grad_cfg_t gcfg;
  pix_t      cur;
  nbr_t      nbr;
  res_t      res, dout;
  logic      accept, is_flush, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= RST_MODE;
      threshold   <= RST_THRESHOLD;
      low_level   <= RST_LOW_LEVEL;
      high_level  <= RST_HIGH_LEVEL;
      colour_mode <= RST_COLOUR_MODE;
      row_width   <= RST_ROW_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:        mode        <= cfg_data[2:0];
        REG_THRESHOLD:   threshold   <= cfg_data;
        REG_LOW_LEVEL:   low_level   <= cfg_data[7:0];
        REG_HIGH_LEVEL:  high_level  <= cfg_data[7:0];
        REG_COLOUR_MODE: colour_mode <= cfg_data[0];
        REG_ROW_WIDTH:   row_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gcfg.mode        = mode;
  assign gcfg.threshold   = threshold;
  assign gcfg.low_level   = low_level;
  assign gcfg.high_level  = high_level;
  assign gcfg.colour_mode = colour_mode;

  assign cur.c0 = pix_c0;
  assign cur.c1 = pix_c1;
  assign cur.c2 = pix_c2;

  assign accept   = in_valid && in_ready;
  assign is_flush = (req_type == REQ_FLUSH);
  // A result exists only when a row is held; otherwise the word just fills
  // the buffer (pixel) or is dropped (flush)
  assign push     = accept && nbr.held;

  gtpf_line_buf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rst      (rst),
    .step     (accept),
    .is_flush (is_flush),
    .cur      (cur),
    .row_width(row_width),
    .nbr      (nbr)
  );

  gtpf_grad u_grad (
    .cfg     (gcfg),
    .nbr     (nbr),
    .is_flush(is_flush),
    .cur     (cur),
    .res     (res)
  );

  gtpf_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (res),
    .out_ready(out_ready),
    .can_take (in_ready),
    .out_valid(out_valid),
    .dout     (dout)
  );

  assign out_c0  = dout.c0;
  assign out_c1  = dout.c1;
  assign out_c2  = dout.c2;
  assign row_end = dout.row_end;

endmodule

// File: src/gtpf_chk.sv
// ----------------------------------------------------------------------------
// gtpf_chk
// Port-level checks for the gradient threshold pixel filter.
// ----------------------------------------------------------------------------
module gtpf_chk (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [2:0]  cfg_index,
  input logic [10:0] cfg_data,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_c0,
  input logic [7:0]  out_c1,
  input logic [7:0]  out_c2,
  input logic        row_end
);
  import gtpf_pkg::*;

  logic colour_q;

  // Track the channel setting from the write port
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_q <= RST_COLOUR_MODE;
    end else if (cfg_we && cfg_index == REG_COLOUR_MODE) begin
      colour_q <= cfg_data[0];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_c0) && $stable(out_c1) &&
                                $stable(out_c2) && $stable(row_end))
    else $error("stalled output word changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output is empty");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !colour_q |-> out_c1 == 8'd0 && out_c2 == 8'd0)
    else $error("gray result with nonzero upper channels");

endmodule

bind gradient_threshold_pixel_filter_core gtpf_chk u_gtpf_chk (.*);
